// ===== rtl/rtpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpf_pkg
// Shared types and constants for the ring topology parent finder.
// ----------------------------------------------------------------------------
package rtpf_pkg;

   localparam int CNT_W    = 9;    // slave number width
   localparam int PCNT_W   = 3;    // port count width
   localparam int MASK_W   = 4;    // port mask width
   localparam int PARENT_W = 8;    // parent number width on the port
   localparam int BAL_W    = 12;   // signed walk-back balance
   localparam int NPORTS   = 4;
   localparam int LINK_W   = 16;
   localparam int RSP_W    = 24;

   localparam logic [CNT_W-1:0]  COUNTER_MAX  = 9'd511;
   localparam logic [1:0]        PORT_OPEN_UP = 2'b10;
   localparam int                PORT_LSB     = 8;

   // port count codes seen during the walk back
   localparam logic [PCNT_W-1:0] PC_END_OF_LINE = 3'd1;
   localparam logic [PCNT_W-1:0] PC_SPLIT       = 3'd3;
   localparam logic [PCNT_W-1:0] PC_CROSS       = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;     // take the input transaction
      logic step;       // table read / evaluate step
      logic load_out;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic need_search;
      logic found;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/rtpf_ram.sv =====
// ----------------------------------------------------------------------------
// rtpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtpf_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rtpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtpf_ctrl
// Controller: sequences accept, parent walk back and result hand-off.
// ----------------------------------------------------------------------------
module rtpf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rtpf_pkg::status_type sts,
   output rtpf_pkg::cmd_type    cmd
);

   rtpf_pkg::state_type state_ff;
   rtpf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtpf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.need_search ? rtpf_pkg::ST_SEARCH : rtpf_pkg::ST_DONE;
            end
         end
         rtpf_pkg::ST_SEARCH: begin
            if (sts.found) begin
               state_in = rtpf_pkg::ST_DONE;
            end
         end
         rtpf_pkg::ST_DONE: begin
            if (sts.out_free) begin
               state_in = rtpf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtpf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         rtpf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         rtpf_pkg::ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         rtpf_pkg::ST_DONE: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/rtpf_dpath.sv =====
// ----------------------------------------------------------------------------
// rtpf_dpath
// Datapath: port decode, slave counter, port count table, walk-back
// evaluator and output register.
// ----------------------------------------------------------------------------
module rtpf_dpath #(
   parameter int MAX_SLAVES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rtpf_pkg::cmd_type                  cmd,
   output rtpf_pkg::status_type               sts,
   input  logic [rtpf_pkg::LINK_W-1:0]        link_status,
   input  logic                               scan_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rtpf_pkg::RSP_W-1:0]         rsp_data,
   output logic                               rsp_overflow
);

   localparam int AW = $clog2(MAX_SLAVES);

   localparam int CW = rtpf_pkg::CNT_W;
   localparam int PW = rtpf_pkg::PCNT_W;
   localparam int BW = rtpf_pkg::BAL_W;

   // input decode
   logic [PW-1:0]               count_dec;
   logic [rtpf_pkg::MASK_W-1:0] mask_dec;
   logic [CW-1:0]               cnt_next;
   logic                        stored;

   always_comb begin
      count_dec = '0;
      mask_dec  = '0;
      for (int n = 0; n < rtpf_pkg::NPORTS; n++) begin
         if (link_status[rtpf_pkg::PORT_LSB + 2*n +: 2] == rtpf_pkg::PORT_OPEN_UP) begin
            count_dec   = count_dec + PW'(1);
            mask_dec[n] = 1'b1;
         end
      end
   end

   logic [CW-1:0] cnt_ff;

   always_comb begin
      if (scan_start) begin
         cnt_next = CW'(1);
      end else if (cnt_ff < rtpf_pkg::COUNTER_MAX) begin
         cnt_next = cnt_ff + CW'(1);
      end else begin
         cnt_next = cnt_ff;
      end
   end

   assign stored = (32'(cnt_next) < 32'(MAX_SLAVES));

   // item registers
   logic [PW-1:0]               count_ff;
   logic [rtpf_pkg::MASK_W-1:0] mask_ff;
   logic                        ovf_ff;
   logic [CW-1:0]               parent_ff;

   // walk-back registers
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        eval_idx_ff;
   logic                 rd_valid_ff;
   logic signed [BW-1:0] bal_ff;

   // table
   logic [31:0]   wr_ext;
   logic [31:0]   rd_ext;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [PW-1:0] rd_data;

   assign wr_ext  = 32'(cnt_next);
   assign rd_ext  = 32'(idx_ff);
   assign wr_addr = wr_ext[AW-1:0];
   assign rd_addr = rd_ext[AW-1:0];

   rtpf_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_SLAVES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.accept && stored),
      .wr_addr (wr_addr),
      .wr_data (count_dec),
      .rd_en   (cmd.step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // evaluate the entry that came back from the table
   logic signed [BW-1:0] delta;
   logic signed [BW-1:0] bal_next;
   logic                 match;

   always_comb begin
      case (rd_data)
         rtpf_pkg::PC_END_OF_LINE: delta = -BW'(1);
         rtpf_pkg::PC_SPLIT:       delta = BW'(1);
         rtpf_pkg::PC_CROSS:       delta = BW'(2);
         default:                  delta = '0;
      endcase
   end

   assign bal_next = bal_ff + delta;
   assign match    = ((!bal_next[BW-1]) && (rd_data > PW'(1))) || (eval_idx_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            cnt_ff      <= cnt_next;
            rd_valid_ff <= 1'b0;
         end else if (cmd.step) begin
            rd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         count_ff  <= count_dec;
         mask_ff   <= mask_dec;
         ovf_ff    <= !stored;
         parent_ff <= '0;
         idx_ff    <= cnt_next - CW'(1);
         bal_ff    <= '0;
      end else if (cmd.step) begin
         eval_idx_ff <= idx_ff;
         // addresses run ahead of evaluation by one read
         idx_ff      <= (idx_ff == '0) ? idx_ff : idx_ff - CW'(1);
         if (rd_valid_ff) begin
            bal_ff <= bal_next;
            if (match) begin
               parent_ff <= eval_idx_ff;
            end
         end
      end
   end

   assign sts.need_search = stored && (cnt_next > CW'(1));
   assign sts.found       = rd_valid_ff && match;

   // output register
   logic                       out_valid_ff;
   logic [rtpf_pkg::RSP_W-1:0] out_data_ff;
   logic                       out_ovf_ff;

   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= {parent_ff[rtpf_pkg::PARENT_W-1:0], mask_ff, count_ff, cnt_ff};
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_overflow = out_ovf_ff;

   // an overflowed slave never reports a parent
   a_ovf_no_parent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ovf_ff |-> out_data_ff[23:16] == '0)
      else $error("overflow result carries a parent");

   // the walk back stops at slave 1 at the latest
   a_walk_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.step && rd_valid_ff |-> eval_idx_ff != '0)
      else $error("walk back evaluated slave 0");

   // a parent always precedes its slave
   a_parent_before: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ovf_ff && out_data_ff[8:0] > CW'(1)
      |-> {1'b0, out_data_ff[23:16]} < out_data_ff[8:0])
      else $error("parent not ahead of slave");

   // after a match the search stops stepping
   a_found_in_search: assert property (@(posedge clock) disable iff (reset)
      sts.found && cmd.step |=> !rd_valid_ff || cmd.load_out || !cmd.step)
      else $error("search kept stepping after a match");

endmodule

// ===== rtl/ring_topology_parent_finder_unit.sv =====
// ----------------------------------------------------------------------------
// ring_topology_parent_finder_unit
// Per-slave port decode and parent search over the stored port counts.
//
//   channel | direction | tdata                        | tuser
//   --------+-----------+------------------------------+-------------
//   req     | in        | link_status                  | scan_start
//   rsp     | out       | slave, count, mask, parent   | overflow
//
// Slave 1 and an overflowed slave need no walk back; any other slave walks
// back over the earlier slaves. The single read port of the port count
// table sets the pace: one stored entry is examined per cycle.
// Reset clears the slave counter and the control state; the table is not
// cleared. A stalled rsp holds the result and blocks the next transaction
// only once the next result is ready.
// ----------------------------------------------------------------------------
module ring_topology_parent_finder_unit #(
   parameter int MAX_SLAVES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // link_status[15:0]
   input  logic        req_tuser,   // scan_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // slave_number[8:0], port_count[11:9],
                                    // port_mask[15:12], parent_number[23:16]
   output logic        rsp_tuser    // overflow
);

   rtpf_pkg::cmd_type    cmd;
   rtpf_pkg::status_type sts;

   rtpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rtpf_dpath #(
      .MAX_SLAVES (MAX_SLAVES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .link_status  (req_tdata),
      .scan_start   (req_tuser),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (rsp_tdata),
      .rsp_overflow (rsp_tuser)
   );

endmodule
